// ===== rtl/core/jch_pkg.sv =====
// ----------------------------------------------------------------------------
// jch_pkg
// shared types and constants of the jump consistent hash core
// ----------------------------------------------------------------------------
package jch_pkg;

    // field widths
    localparam int KeyW    = 64;
    localparam int BucketW = 31;
    localparam int HalfW   = 32;
    localparam int DenW    = 32;
    localparam int QuotW   = 62;
    localparam int KeyTopShift = 33;

    // 64-bit linear congruential multiplier
    localparam logic [KeyW-1:0] LcgMult = 64'h27BB2EE687B0B0FD;

    localparam logic [BucketW-1:0] BucketCountReset = 31'd1024;

    // lcg partial product sequence
    localparam logic [1:0] LCG_STEP_LO_LO = 2'd0;
    localparam logic [1:0] LCG_STEP_HI_LO = 2'd1;
    localparam logic [1:0] LCG_STEP_LO_HI = 2'd2;
    localparam logic [1:0] LCG_STEP_LAST  = 2'd3;

    // radix-4 divider: two quotient bits per cycle
    localparam int DivSteps = QuotW / 2;
    localparam int DivCntW  = $clog2(DivSteps);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LCG,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

// ===== rtl/core/jump_consistent_hash_core.sv =====
// ----------------------------------------------------------------------------
// jump_consistent_hash_core
// maps a 64-bit key to a bucket below bucket_count (bucket 0 when it is zero) by jump consistent hashing
// ----------------------------------------------------------------------------
//
//  channel   signals                         direction  payload
//  -------   ------------------------------  ---------  -----------------------
//  in        in_valid / in_ready             request    key [63:0]
//  out       out_valid / out_ready           result     bucket [30:0]
//  cfg       cfg_we                          write      cfg_wdata [30:0]
//
//  each jump iteration runs the lcg step on the shared 32x32 multiplier, then
//  the radix-4 divider, then a compare of the quotient against bucket_count
//  a request runs one iteration per jump taken, about ln(bucket_count)+1 jumps
//  in_ready is high only in idle; one request is worked at a time
//  a finished bucket sits in the output register while the next request runs
//  reset (rst_n low, async) returns to idle and sets bucket_count to 1024
// ----------------------------------------------------------------------------
module jump_consistent_hash_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [jch_pkg::KeyW-1:0]        key,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [jch_pkg::BucketW-1:0]     bucket,
    input  logic                            cfg_we,
    input  logic [jch_pkg::BucketW-1:0]     cfg_wdata
);

    jch_pkg::state_t                   state_reg;
    jch_pkg::state_t                   state_next;

    logic [jch_pkg::BucketW-1:0]       bucket_count_reg;
    logic [jch_pkg::KeyW-1:0]          key_reg;
    logic [jch_pkg::BucketW-1:0]       b_reg;
    logic [jch_pkg::BucketW-1:0]       bucket_reg;
    logic                              out_valid_reg;

    // unit handshakes
    logic                              lcg_start;
    logic [jch_pkg::KeyW-1:0]          lcg_key_in;
    logic [jch_pkg::KeyW-1:0]          lcg_key_out;
    jch_pkg::unit_status_t             lcg_status;
    logic                              div_start;
    logic [jch_pkg::BucketW-1:0]       div_num;
    logic [jch_pkg::DenW-1:0]          div_den;
    logic [jch_pkg::QuotW-1:0]         div_quot;
    jch_pkg::unit_status_t             div_status;

    logic                              in_accept;
    logic                              out_free;
    logic                              out_load;
    logic                              count_zero;
    logic                              more_jumps;

    assign count_zero = (bucket_count_reg == '0);
    assign out_free   = !out_valid_reg || out_ready;
    assign in_accept  = in_valid && in_ready;

    // next jump still inside the bucket range
    assign more_jumps = (div_quot <
        {{(jch_pkg::QuotW - jch_pkg::BucketW){1'b0}}, bucket_count_reg});

    // divider operands: (b + 1) << 31 over (key >> 33) + 1
    assign div_num = b_reg + 1'b1;
    assign div_den = jch_pkg::DenW'(lcg_key_out[jch_pkg::KeyW-1:jch_pkg::KeyTopShift])
                     + 1'b1;

    jch_lcg u_lcg (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (lcg_start),
        .key_in  (lcg_key_in),
        .key_out (lcg_key_out),
        .status  (lcg_status)
    );

    jch_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num_hi (div_num),
        .den    (div_den),
        .quot   (div_quot),
        .status (div_status)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            jch_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = count_zero ? jch_pkg::ST_DONE : jch_pkg::ST_LCG;
                end
            end
            jch_pkg::ST_LCG:
            begin
                if (lcg_status.done)
                begin
                    state_next = jch_pkg::ST_DIV;
                end
            end
            jch_pkg::ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = more_jumps ? jch_pkg::ST_LCG : jch_pkg::ST_DONE;
                end
            end
            jch_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = jch_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = jch_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready   = 1'b0;
        lcg_start  = 1'b0;
        lcg_key_in = key_reg;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            jch_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                lcg_key_in = key;
                lcg_start  = in_valid && !count_zero;
            end
            jch_pkg::ST_LCG:
            begin
                div_start = lcg_status.done;
            end
            jch_pkg::ST_DIV:
            begin
                lcg_start = div_status.done && more_jumps;
            end
            jch_pkg::ST_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= jch_pkg::ST_IDLE;
            bucket_count_reg <= jch_pkg::BucketCountReset;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                bucket_count_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working key, current bucket and result
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            key_reg <= key;
            b_reg   <= '0;
        end
        if ((state_reg == jch_pkg::ST_LCG) && lcg_status.done)
        begin
            key_reg <= lcg_key_out;
        end
        if ((state_reg == jch_pkg::ST_DIV) && div_status.done && more_jumps)
        begin
            b_reg <= div_quot[jch_pkg::BucketW-1:0];
        end
        if (out_load)
        begin
            bucket_reg <= b_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign bucket    = bucket_reg;

    // the two arithmetic units never run at the same time
    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(lcg_status.busy && div_status.busy))
        else $error("lcg and divider busy together");

    // a result is inside the bucket range whenever bucket_count is not zero
    a_bucket_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !count_zero) |-> (bucket < bucket_count_reg))
        else $error("bucket not below bucket_count");

    // divider completes only while the sequencer waits on it
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == jch_pkg::ST_DIV))
        else $error("divider done outside divide state");

    // a started lcg step is busy on the next cycle
    a_lcg_starts: assert property (@(posedge clk) disable iff (!rst_n)
        lcg_start |=> lcg_status.busy)
        else $error("lcg did not start");

endmodule

// ===== rtl/core/jch_lcg.sv =====
// ----------------------------------------------------------------------------
// jch_lcg
// 64-bit lcg step key * mult + 1 on one shared 32x32 multiplier
// ----------------------------------------------------------------------------
module jch_lcg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [jch_pkg::KeyW-1:0]      key_in,
    output logic [jch_pkg::KeyW-1:0]      key_out,
    output jch_pkg::unit_status_t         status
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [1:0]                      step_reg;
    logic [jch_pkg::KeyW-1:0]        key_reg;
    logic [jch_pkg::KeyW-1:0]        prod_reg;
    logic [jch_pkg::KeyW-1:0]        acc_reg;
    logic [jch_pkg::HalfW-1:0]       op_a;
    logic [jch_pkg::HalfW-1:0]       op_b;
    logic [jch_pkg::KeyW-1:0]        prod_next;

    // operand select per partial product
    always_comb
    begin
        op_a = key_reg[jch_pkg::HalfW-1:0];
        op_b = jch_pkg::LcgMult[jch_pkg::HalfW-1:0];
        case (step_reg)
            jch_pkg::LCG_STEP_HI_LO:
            begin
                op_a = key_reg[jch_pkg::KeyW-1:jch_pkg::HalfW];
            end
            jch_pkg::LCG_STEP_LO_HI:
            begin
                op_b = jch_pkg::LcgMult[jch_pkg::KeyW-1:jch_pkg::HalfW];
            end
            default:
            begin
                op_a = key_reg[jch_pkg::HalfW-1:0];
            end
        endcase
    end

    assign prod_next = op_a * op_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= jch_pkg::LCG_STEP_LO_LO;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= jch_pkg::LCG_STEP_LO_LO;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 2'd1;
            if (step_reg == jch_pkg::LCG_STEP_LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // product is registered, accumulated in the following cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            key_reg <= key_in;
        end
        if (busy_reg)
        begin
            prod_reg <= prod_next;
            case (step_reg)
                jch_pkg::LCG_STEP_HI_LO:
                begin
                    acc_reg <= prod_reg + 64'd1;
                end
                jch_pkg::LCG_STEP_LO_HI,
                jch_pkg::LCG_STEP_LAST:
                begin
                    acc_reg[jch_pkg::KeyW-1:jch_pkg::HalfW] <=
                        acc_reg[jch_pkg::KeyW-1:jch_pkg::HalfW]
                        + prod_reg[jch_pkg::HalfW-1:0];
                end
                default:
                begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

    assign key_out     = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== rtl/core/jch_div.sv =====
// ----------------------------------------------------------------------------
// jch_div
// radix-4 restoring divider for (num << 31) / den
// ----------------------------------------------------------------------------
module jch_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [jch_pkg::BucketW-1:0]     num_hi,
    input  logic [jch_pkg::DenW-1:0]        den,
    output logic [jch_pkg::QuotW-1:0]       quot,
    output jch_pkg::unit_status_t           status
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [jch_pkg::DivCntW-1:0]     cnt_reg;
    logic [jch_pkg::QuotW-1:0]       dq_reg;
    logic [jch_pkg::DenW-1:0]        rem_reg;
    logic [jch_pkg::DenW-1:0]        den_reg;

    logic [jch_pkg::DenW:0]          trial1;
    logic [jch_pkg::DenW:0]          trial2;
    logic                            ge1;
    logic                            ge2;
    logic [jch_pkg::DenW-1:0]        rem1;
    logic [jch_pkg::DenW-1:0]        rem2;

    // two shift-subtract steps; remainder stays below den
    always_comb
    begin
        trial1 = {rem_reg, dq_reg[jch_pkg::QuotW-1]};
        ge1    = (trial1 >= {1'b0, den_reg});
        rem1   = ge1 ? jch_pkg::DenW'(trial1 - {1'b0, den_reg})
                     : trial1[jch_pkg::DenW-1:0];
        trial2 = {rem1, dq_reg[jch_pkg::QuotW-2]};
        ge2    = (trial2 >= {1'b0, den_reg});
        rem2   = ge2 ? jch_pkg::DenW'(trial2 - {1'b0, den_reg})
                     : trial2[jch_pkg::DenW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == jch_pkg::DivCntW'(jch_pkg::DivSteps - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= {num_hi, {(jch_pkg::QuotW - jch_pkg::BucketW){1'b0}}};
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[jch_pkg::QuotW-3:0], ge1, ge2};
            rem_reg <= rem2;
        end
    end

    assign quot        = dq_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== tb/jch_bucket_checker.sv =====
// ----------------------------------------------------------------------------
// jch_bucket_checker
// watches the key, bucket and config ports, predicts each bucket and compares
// ----------------------------------------------------------------------------
module jch_bucket_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [jch_pkg::KeyW-1:0]       key,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [jch_pkg::BucketW-1:0]    bucket,
    input  logic                           cfg_we,
    input  logic [jch_pkg::BucketW-1:0]    cfg_wdata,
    output int                             mismatches,
    output int                             awaiting
);

    localparam int JumpScaleShift = 31;

    logic [jch_pkg::BucketW-1:0] buckets_now;
    logic [jch_pkg::BucketW-1:0] bucket_expect_q[$];

    // exact integer jump hash
    function automatic logic [jch_pkg::BucketW-1:0] jump_bucket_of(
        input logic [jch_pkg::KeyW-1:0]    k,
        input logic [jch_pkg::BucketW-1:0] n
    );
        logic [63:0] walk;
        logic [63:0] b;
        logic [63:0] j;
        logic [63:0] den;
        walk = k;
        b    = 64'd0;
        j    = 64'd0;
        while (j < {33'd0, n})
        begin
            b    = j;
            walk = walk * jch_pkg::LcgMult + 64'd1;
            den  = (walk >> jch_pkg::KeyTopShift) + 64'd1;
            j    = ((b + 64'd1) << JumpScaleShift) / den;
        end
        return b[jch_pkg::BucketW-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [jch_pkg::BucketW-1:0] want;
        if (!rst_n)
        begin
            buckets_now <= jch_pkg::BucketCountReset;
            bucket_expect_q.delete();
            awaiting    <= 0;
            mismatches  <= 0;
        end
        else
        begin
            // the bench must make config writes only while idle; neither core nor checker enforces it
            if (cfg_we)
                buckets_now <= cfg_wdata;
            if (in_valid && in_ready)
                bucket_expect_q.push_back(jump_bucket_of(key, buckets_now));
            if (out_valid && out_ready)
            begin
                if (bucket_expect_q.size() == 0)
                begin
                    $error("bucket: no request waiting, actual %0d", bucket);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = bucket_expect_q.pop_front();
                    if (bucket !== want)
                    begin
                        $error("bucket: expected %0d, actual %0d", want, bucket);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            awaiting <= bucket_expect_q.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// jump consistent hash core: keys are pushed through the request channel under
// a series of bucket counts, and every returned bucket is checked against an
// exact integer prediction by the checker that sits beside the core
// ----------------------------------------------------------------------------
module testbench;

    // a request at the widest count takes a few dozen jumps,
    // so the limit leaves many times the slowest plausible run
    localparam int CycleLimit = 8_000_000;
    // idle chance in percent for both the sender and the receiver
    localparam int IdlePct    = 18;
    // quiet cycles after the last bucket
    localparam int DrainHold  = 100;
    localparam logic [jch_pkg::BucketW-1:0] BucketMax = '1;

    logic                           clk;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    logic [jch_pkg::KeyW-1:0]       key       = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [jch_pkg::BucketW-1:0]    bucket;
    logic                           cfg_we    = 1'b0;
    logic [jch_pkg::BucketW-1:0]    cfg_wdata = '0;

    // when set, neither side idles
    logic steady = 1'b0;

    int mismatches;
    int awaiting;
    int requests_sent = 0;
    int settings_used = 1;

    jump_consistent_hash_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .key       (key),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .bucket    (bucket),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    jch_bucket_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .key        (key),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .bucket     (bucket),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver stalls at random, except in the steady stretch
    always @(posedge clk)
        out_ready <= steady || ($urandom_range(99) >= IdlePct);

    // hang guard
    initial
    begin : watchdog
        repeat (CycleLimit) @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // one request: optional idle gap, then hold valid until accepted
    // valid is dropped only in the gap or by wait_all_buckets, so a back-to-back request keeps it high
    task automatic offer_key(input logic [jch_pkg::KeyW-1:0] k);
        while (!steady && $urandom_range(99) < IdlePct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        key      <= k;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        requests_sent++;
    endtask

    // stop sending and wait for every predicted bucket to come back
    // the first edge lets the checker count the request just accepted
    task automatic wait_all_buckets;
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
    endtask

    // config is only written with the core idle and nothing outstanding
    task automatic set_bucket_count(input logic [jch_pkg::BucketW-1:0] n);
        wait_all_buckets();
        cfg_wdata <= n;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // mostly full-width random keys, with one-hot, one-cold and short keys mixed in
    function automatic logic [jch_pkg::KeyW-1:0] pick_key();
        logic [jch_pkg::KeyW-1:0] k;
        case ($urandom_range(9))
            0:       k = 64'd1 << $urandom_range(63);
            1:       k = ~(64'd1 << $urandom_range(63));
            2:       k = {32'd0, $urandom};
            default: k = {$urandom, $urandom};
        endcase
        return k;
    endfunction

    // small counts are cheap; small and middle counts are each twice as common as wide counts, which take many jumps
    function automatic logic [jch_pkg::BucketW-1:0] pick_bucket_count();
        logic [jch_pkg::BucketW-1:0] n;
        case ($urandom_range(4))
            0, 1:    n = jch_pkg::BucketW'($urandom_range(64, 1));
            2, 3:    n = jch_pkg::BucketW'($urandom_range(65535, 65));
            default: n = jch_pkg::BucketW'($urandom_range(32'h7FFF_FFFF, 65536));
        endcase
        return n;
    endfunction

    task automatic run_key_batch(input int count);
        for (int i = 0; i < count; i++)
        begin
            // now and then the sender holds off until the core has drained
            if ($urandom_range(299) == 0)
                wait_all_buckets();
            offer_key(pick_key());
        end
    endtask

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed keys under the reset count of 1024
        offer_key(64'd0);
        offer_key('1);
        offer_key(64'd1);
        offer_key(64'h8000_0000_0000_0000);
        offer_key(64'h7FFF_FFFF_FFFF_FFFF);
        offer_key(64'hAAAA_AAAA_AAAA_AAAA);
        offer_key(64'h5555_5555_5555_5555);
        offer_key(64'h0000_0001_0000_0000);

        // single bucket: always bucket 0
        set_bucket_count(31'd1);
        offer_key(64'd0);
        offer_key('1);
        offer_key(pick_key());
        offer_key(pick_key());

        // zero buckets: the jump loop never runs, bucket 0
        set_bucket_count(31'd0);
        offer_key(64'd0);
        offer_key('1);
        offer_key(pick_key());
        offer_key(pick_key());

        // widest count, longest jump chains
        set_bucket_count(BucketMax);
        offer_key(64'd0);
        offer_key('1);
        offer_key(64'h5555_5555_5555_5555);
        offer_key(64'h8000_0000_0000_0000);

        // random part over a spread of counts
        set_bucket_count(31'd2);
        run_key_batch(150);
        set_bucket_count(31'd3);
        run_key_batch(100);
        repeat (12)
        begin
            set_bucket_count(pick_bucket_count());
            run_key_batch(120);
        end
        set_bucket_count(BucketMax);
        run_key_batch(60);

        // back to the reset count with both sides running flat out
        set_bucket_count(jch_pkg::BucketCountReset);
        steady <= 1'b1;
        run_key_batch(100);
        steady <= 1'b0;

        // drain, then give the core a little longer to misbehave
        wait_all_buckets();
        repeat (DrainHold) @(posedge clk);

        $display("covered %0d requests over %0d bucket-count settings, from 0 to %0d",
                 requests_sent, settings_used, BucketMax);
        $display("with field-extreme keys, one and zero buckets, a no-stall stretch and drains");
        if (mismatches == 0 && awaiting == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/jch_pkg.sv
rtl/core/jch_lcg.sv
rtl/core/jch_div.sv
rtl/core/jump_consistent_hash_core.sv
tb/jch_bucket_checker.sv
tb/testbench.sv
